@@ src/lpfr_pkg.sv @@
// shared types and constants for the length-prefixed frame receiver
// used by lpfr_ctrl, lpfr_dp and the top level; no dependencies
`default_nettype none

package lpfr_pkg;

	localparam int unsigned MAX_FRAME_LEN = 16;
	localparam int unsigned STORE_DEPTH   = 16;
	localparam int unsigned FRAME_LIMIT   =
		(MAX_FRAME_LEN > STORE_DEPTH) ? STORE_DEPTH : MAX_FRAME_LEN;

	localparam int unsigned IDX_W = 4;
	localparam int unsigned LEN_W = 5;

	localparam logic [7:0] HEADER_BYTE = 8'hF0;
	localparam logic       ENABLE_ON   = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_CMD,
		PH_PRM,
		PH_EMIT
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic restart;
		logic take_len;
		logic take_cmd;
		logic take_prm;
		logic emit_load;
	} lpfr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hdr_match;
		logic len_zero;
		logic rem_one;
		logic emit_last;
		logic out_free;
	} lpfr_sts_t;

endpackage

`default_nettype wire

@@ src/length_prefixed_frame_receiver.sv @@
// Length-prefixed frame receiver: header 0xF0, length, command, parameters.
// Bytes are taken one per cycle while a frame is parsed. When a frame
// completes, its results leave the output register one per cycle unless
// the output stalls (one result, or one per parameter, up to 15), read
// from the single port of the parameter store; during that run in_ready and
// cfg_ready stay low, so a frame holds off input until its last result is
// loaded, output stalls included. rx_enable resets to 0; writing 1 restarts
// the header hunt, and while it is 0 incoming bytes are taken and dropped.
// Depends on lpfr_pkg, lpfr_ctrl and lpfr_dp.
`default_nettype none

module length_prefixed_frame_receiver
	import lpfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        rx_enable,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       msg_type,
	output logic [IDX_W-1:0] param_count,
	output logic             has_param,
	output logic [IDX_W-1:0] param_index,
	output logic [7:0]       param_byte,
	output logic             last
);

	lpfr_cmd_t cmd;
	lpfr_sts_t sts;

	lpfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (rx_enable),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpfr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.msg_type    (msg_type),
		.param_count (param_count),
		.has_param   (has_param),
		.param_index (param_index),
		.param_byte  (param_byte),
		.last        (last)
	);

	// no input transaction while results are read out
	a_no_parse_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> !in_ready)
		else $error("input accepted during result readout");

	// a frame without parameters is a single result
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_param) |-> (last && param_count == '0))
		else $error("parameterless result not marked last");

	// parameter index stays inside the frame
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_param) |-> (param_index < param_count))
		else $error("parameter index beyond count");

	// last result of a run sits at the final index
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_param && last) |-> (param_index == param_count - 4'd1))
		else $error("last flag at wrong index");

endmodule

`default_nettype wire

@@ src/lpfr_ctrl.sv @@
// parser state machine of the frame receiver, holds the enable register
// depends on lpfr_pkg
`default_nettype none

module lpfr_ctrl
	import lpfr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_data,
	input  wire lpfr_sts_t sts,
	output lpfr_cmd_t      cmd
);

	phase_t state_q, state_d;
	logic   enable_q;
	logic   in_take;
	logic   cfg_take;

	assign in_ready  = (state_q != PH_EMIT);
	assign cfg_ready = (state_q != PH_EMIT);
	assign in_take   = in_valid && in_ready && enable_q;
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PH_HUNT;
			enable_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_take)
				enable_q <= cfg_data;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_HUNT: begin
				if (in_take && sts.hdr_match)
					state_d = PH_LEN;
			end
			PH_LEN: begin
				if (in_take)
					state_d = sts.len_zero ? PH_HUNT : PH_CMD;
			end
			PH_CMD: begin
				if (in_take)
					state_d = sts.rem_one ? PH_EMIT : PH_PRM;
			end
			PH_PRM: begin
				if (in_take && sts.rem_one)
					state_d = PH_EMIT;
			end
			PH_EMIT: begin
				if (sts.out_free && sts.emit_last)
					state_d = PH_HUNT;
			end
			default: state_d = PH_HUNT;
		endcase
		// enabling restarts the header hunt
		if (cfg_take && cfg_data == ENABLE_ON)
			state_d = PH_HUNT;
	end

	always_comb begin
		cmd           = '0;
		cmd.restart   = cfg_take && (cfg_data == ENABLE_ON);
		cmd.take_len  = in_take && (state_q == PH_LEN) && !sts.len_zero;
		cmd.take_cmd  = in_take && (state_q == PH_CMD);
		cmd.take_prm  = in_take && (state_q == PH_PRM);
		cmd.emit_load = (state_q == PH_EMIT) && sts.out_free;
	end

endmodule

`default_nettype wire

@@ src/lpfr_dp.sv @@
// datapath of the frame receiver: counters, command hold, parameter store
// and the result output register; depends on lpfr_pkg
`default_nettype none

module lpfr_dp
	import lpfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  rx_byte,
	input  wire lpfr_cmd_t   cmd,
	output lpfr_sts_t        sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       msg_type,
	output logic [IDX_W-1:0] param_count,
	output logic             has_param,
	output logic [IDX_W-1:0] param_index,
	output logic [7:0]       param_byte,
	output logic             last
);

	logic [7:0]       store_q [STORE_DEPTH];
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] frame_len_q;
	logic [7:0]       command_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             out_valid_q;
	logic [7:0]       msg_type_q;
	logic [IDX_W-1:0] param_count_q;
	logic             has_param_q;
	logic [IDX_W-1:0] param_index_q;
	logic [7:0]       param_byte_q;
	logic             last_q;

	logic [LEN_W-1:0] len_clamped;
	logic [IDX_W-1:0] count;
	logic             count_zero;
	logic             rd_last;

	assign len_clamped = (rx_byte > 8'(FRAME_LIMIT)) ? LEN_W'(FRAME_LIMIT)
		: rx_byte[LEN_W-1:0];
	assign count       = IDX_W'(frame_len_q - LEN_W'(1));
	assign count_zero  = (count == '0);
	assign rd_last     = count_zero || (rd_idx_q == IDX_W'(count - IDX_W'(1)));

	assign sts.hdr_match = (rx_byte == HEADER_BYTE);
	assign sts.len_zero  = (len_clamped == '0);
	assign sts.rem_one   = (rem_q == LEN_W'(1));
	assign sts.emit_last = rd_last;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				rem_q    <= '0;
				wr_idx_q <= '0;
			end else if (cmd.take_len) begin
				rem_q    <= len_clamped;
				wr_idx_q <= '0;
			end else if (cmd.take_cmd) begin
				rem_q    <= rem_q - LEN_W'(1);
				rd_idx_q <= '0;
			end else if (cmd.take_prm) begin
				rem_q    <= rem_q - LEN_W'(1);
				wr_idx_q <= wr_idx_q + IDX_W'(1);
			end

			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
				rd_idx_q    <= rd_idx_q + IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers and parameter store
	always_ff @(posedge clk) begin
		if (cmd.take_len)
			frame_len_q <= len_clamped;
		if (cmd.take_cmd)
			command_q <= rx_byte;
		if (cmd.take_prm)
			store_q[wr_idx_q] <= rx_byte;
		if (cmd.emit_load) begin
			msg_type_q    <= command_q;
			param_count_q <= count;
			has_param_q   <= !count_zero;
			param_index_q <= count_zero ? '0 : rd_idx_q;
			param_byte_q  <= count_zero ? '0 : store_q[rd_idx_q];
			last_q        <= rd_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign msg_type    = msg_type_q;
	assign param_count = param_count_q;
	assign has_param   = has_param_q;
	assign param_index = param_index_q;
	assign param_byte  = param_byte_q;
	assign last        = last_q;

endmodule

`default_nettype wire

@@ sim/length_prefixed_frame_receiver_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for length_prefixed_frame_receiver
// walks a directed frame table, then random frames, and checks results against a parser model
// depends on lpfr_pkg and the receiver rtl

module length_prefixed_frame_receiver_tb;
	import lpfr_pkg::*;

	typedef struct packed {
		logic [7:0]       msg_type;
		logic [IDX_W-1:0] param_count;
		logic             has_param;
		logic [IDX_W-1:0] param_index;
		logic [7:0]       param_byte;
		logic             last;
	} frame_result_t;

	typedef enum logic {ROW_BYTE, ROW_ENABLE} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [7:0]    value;
		logic          fixed;
		frame_result_t result;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       rx_byte = 8'h00;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             rx_enable = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       msg_type;
	logic [IDX_W-1:0] param_count;
	logic             has_param;
	logic [IDX_W-1:0] param_index;
	logic [7:0]       param_byte;
	logic             last;

	length_prefixed_frame_receiver dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.rx_enable   (rx_enable),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.msg_type    (msg_type),
		.param_count (param_count),
		.has_param   (has_param),
		.param_index (param_index),
		.param_byte  (param_byte),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	logic             rx_on = 1'b0;
	phase_t           parse_state = PH_HUNT;
	logic [LEN_W-1:0] bytes_left = '0;
	logic [LEN_W-1:0] frame_len = '0;
	logic [7:0]       cmd_byte = 8'h00;
	logic [IDX_W-1:0] wr_idx = '0;
	logic [7:0]       param_buf [STORE_DEPTH];
	frame_result_t    pending_results [$];

	int unsigned bytes_parsed = 0;
	int unsigned bytes_ignored = 0;
	int unsigned frames_done = 0;
	int unsigned results_seen = 0;
	int unsigned enable_writes = 0;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	bit          idle_free = 1'b0;

	stim_row_t directed_rows [25];

	task automatic queue_frame_results();
		frame_result_t r;
		int unsigned   n;
		int unsigned   i;
		n = int'(frame_len) - 1;
		frames_done++;
		r = '0;
		r.msg_type = cmd_byte;
		if (n == 0) begin
			r.last = 1'b1;
			pending_results.push_back(r);
		end else begin
			for (i = 0; i < n; i++) begin
				r.param_count = IDX_W'(n);
				r.has_param   = 1'b1;
				r.param_index = IDX_W'(i);
				r.param_byte  = param_buf[i];
				r.last        = (i == n - 1);
				pending_results.push_back(r);
			end
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		int unsigned len;
		if (rx_on) begin
			case (parse_state)
				PH_HUNT: begin
					if (b == HEADER_BYTE) begin
						parse_state = PH_LEN;
						wr_idx = '0;
					end
				end
				PH_LEN: begin
					len = (b > FRAME_LIMIT) ? FRAME_LIMIT : b;
					if (len == 0) begin
						parse_state = PH_HUNT;
					end else begin
						frame_len   = LEN_W'(len);
						bytes_left  = LEN_W'(len);
						wr_idx      = '0;
						parse_state = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_byte = b;
					bytes_left--;
					if (bytes_left == 0) begin
						parse_state = PH_HUNT;
						queue_frame_results();
					end else begin
						parse_state = PH_PRM;
					end
				end
				default: begin
					param_buf[wr_idx] = b;
					wr_idx++;
					bytes_left--;
					if (bytes_left == 0) begin
						parse_state = PH_HUNT;
						queue_frame_results();
					end
				end
			endcase
		end
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_byte(input logic [7:0] b, input logic fixed, input frame_result_t want);
		int unsigned gap;
		int          n0;
		if (burst_left == 0) begin
			gap = idle_free ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (rx_on)
			bytes_parsed++;
		else
			bytes_ignored++;
		n0 = pending_results.size();
		parse_byte(b);
		// hand-written expectation replaces what the model would predict
		if (fixed) begin
			while (pending_results.size() > n0) void'(pending_results.pop_back());
			pending_results.push_back(want);
		end
		@(negedge clk);
	endtask

	task automatic write_enable(input logic v);
		cfg_valid <= 1'b1;
		rx_enable <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rx_on = v;
		if (v == ENABLE_ON) begin
			parse_state = PH_HUNT;
			bytes_left  = '0;
			wr_idx      = '0;
		end
		enable_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain all results, then give the block time to settle a byte with no result
	task automatic wait_quiet();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_frame();
		int unsigned pick;
		int unsigned len;
		int unsigned body;
		int unsigned i;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			// line noise outside a frame
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
		end else begin
			if (pick == 1)
				len = 0;
			else if (pick < 14)
				len = $urandom_range(1, 5);
			else if (pick < 18)
				len = $urandom_range(6, 16);
			else
				len = $urandom_range(17, 255);
			body = (len > FRAME_LIMIT) ? FRAME_LIMIT : len;
			// truncated frame, the next header gets swallowed as data
			if ((pick == 2 || pick == 3) && body > 1)
				body = $urandom_range(1, body - 1);
			send_byte(HEADER_BYTE, 1'b0, '0);
			send_byte(8'(len), 1'b0, '0);
			for (i = 0; i < body; i++) send_byte(8'($urandom), 1'b0, '0);
			if ($urandom_range(0, 7) == 0)
				wait_quiet();
		end
	endtask

	task automatic note_mismatch(input string what, input frame_result_t want,
			input frame_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected type %h count %0d has %b idx %0d byte %h last %b",
				$realtime, what, want.msg_type, want.param_count, want.has_param,
				want.param_index, want.param_byte, want.last);
			$display("    got type %h count %0d has %b idx %0d byte %h last %b",
				got.msg_type, got.param_count, got.has_param, got.param_index,
				got.param_byte, got.last);
		end
	endtask

	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {msg_type, param_count, has_param, param_index, param_byte, last};
			results_seen++;
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	// receiver: a new mode is drawn whenever rx_cycle wraps; mode 0 starts no stalls of its own
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	logic [5:0]  rx_cycle = '0;

	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		if (rx_cycle == 0)
			stall_mode <= $urandom_range(0, 2);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
			stall_left <= $urandom_range(1, 20);
			out_ready  <= 1'b0;
		end else if (stall_mode == 0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int unsigned rand_base;
		int unsigned phase_no;
		logic        en;
		directed_rows = '{
			'{ROW_BYTE,   8'hF0, 1'b0, '0},                     // ignored while disabled
			'{ROW_ENABLE, 8'(ENABLE_ON), 1'b0, '0},
			'{ROW_BYTE,   8'hF0, 1'b0, '0},
			'{ROW_BYTE,   8'h01, 1'b0, '0},                     // length one
			'{ROW_BYTE,   8'h00, 1'b1, '{8'h00, 4'd0, 1'b0, 4'd0, 8'h00, 1'b1}},
			'{ROW_BYTE,   8'hF0, 1'b0, '0},
			'{ROW_BYTE,   8'h00, 1'b0, '0},                     // zero length, back to hunt
			'{ROW_BYTE,   8'hF0, 1'b0, '0},
			'{ROW_BYTE,   8'hFF, 1'b0, '0},                     // clamped to the limit
			'{ROW_BYTE,   8'hF0, 1'b0, '0},                     // header value as command
			'{ROW_BYTE,   8'hF0, 1'b0, '0},
			'{ROW_BYTE,   8'h00, 1'b0, '0},
			'{ROW_BYTE,   8'hFF, 1'b0, '0},
			'{ROW_BYTE,   8'h55, 1'b0, '0},
			'{ROW_BYTE,   8'hAA, 1'b0, '0},
			'{ROW_BYTE,   8'h01, 1'b0, '0},
			'{ROW_BYTE,   8'h80, 1'b0, '0},
			'{ROW_BYTE,   8'h7F, 1'b0, '0},
			'{ROW_BYTE,   8'h02, 1'b0, '0},
			'{ROW_BYTE,   8'h04, 1'b0, '0},
			'{ROW_BYTE,   8'h08, 1'b0, '0},
			'{ROW_BYTE,   8'h10, 1'b0, '0},
			'{ROW_BYTE,   8'h20, 1'b0, '0},
			'{ROW_BYTE,   8'h40, 1'b0, '0},
			'{ROW_BYTE,   8'hFE, 1'b0, '0}
		};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_ENABLE) begin
				wait_quiet();
				write_enable(directed_rows[k].value[0]);
			end else begin
				send_byte(directed_rows[k].value, directed_rows[k].fixed,
					directed_rows[k].result);
			end
		end

		rand_base = bytes_parsed;
		phase_no = 0;
		while (bytes_parsed - rand_base < 160) begin
			en = (phase_no == 0) ? 1'b0 : ($urandom_range(0, 5) != 0);
			wait_quiet();
			write_enable(en);
			idle_free = ($urandom_range(0, 3) == 0);
			if (!en) begin
				repeat ($urandom_range(2, 5)) send_byte(8'($urandom), 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 4)) send_frame();
			end
			phase_no++;
		end

		wait_quiet();
		repeat (20) @(negedge clk);
		$display("run: %0d bytes parsed, %0d dropped while disabled, %0d enable writes",
			bytes_parsed, bytes_ignored, enable_writes);
		$display("run: %0d frames completed, %0d results checked, %0d mismatches",
			frames_done, results_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/lpfr_pkg.sv
src/lpfr_ctrl.sv
src/lpfr_dp.sv
src/length_prefixed_frame_receiver.sv
sim/length_prefixed_frame_receiver_tb.sv
